[hw/rtl/plr_pkg.sv]
package plr_pkg;

	localparam int NUM_SENSORS_DEF = 8;
	localparam int MAX_SENSORS     = 8;

	localparam int CNT_W  = 12;
	localparam int RAD_W  = 10;
	localparam int ANG_W  = 12;
	localparam int DEG_W  = 9;
	localparam int INT_W  = 12;
	localparam int LL_W   = 48;
	localparam int LANE_W = 38;
	localparam int DIV_W  = 30;
	localparam int DVS_W  = 10;

	localparam int FULL_TURN     = 360;
	localparam int HALF_TURN     = 180;
	localparam int QUARTER_TURN  = 90;
	localparam int THREE_QUARTER = 270;

	localparam longint unsigned DEG_RAD_Q30 = 64'd18740330;
	localparam logic [30:0] LOG2E_Q30   = 31'd1549082005;
	localparam logic [29:0] LN2_Q30     = 30'd744261118;
	localparam logic signed [22:0] LN_2P16_Q16 = 23'sd726817;

	localparam int PADDR_W = 4;

	localparam logic [1:0] REG_RING_RADIUS = 2'd0;
	localparam logic [1:0] REG_ATTEN_LEN   = 2'd1;
	localparam logic [1:0] REG_SPACING     = 2'd2;

	localparam int COS_DEPTH = 128;
	typedef logic [16:0] cos_tab_t [COS_DEPTH];

	// shift-subtract quotient, only used while building the table
	function automatic longint unsigned udiv64(longint unsigned num,
			longint unsigned den);
		longint unsigned quo, rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// cos(k deg) in Q16 for k = 0..90, Taylor series in Q30; unused entries zero
	function automatic cos_tab_t build_cos_tab();
		cos_tab_t tab;
		longint unsigned x, x2, term, dv;
		longint sum;
		for (int k = 0; k < COS_DEPTH; k++) begin
			tab[k] = '0;
			if (k <= QUARTER_TURN) begin
				x    = 64'(k) * DEG_RAD_Q30;
				x2   = (x * x) >> 30;
				term = 64'd1 << 30;
				sum  = 64'sd1 << 30;
				for (int i = 1; i <= 10; i++) begin
					dv   = 64'((2 * i - 1) * (2 * i));
					term = udiv64((term * x2) >> 30, dv);
					if ((i % 2) == 1) sum = sum - longint'(term);
					else sum = sum + longint'(term);
				end
				if (sum < 0) sum = 0;
				tab[k] = 17'((64'(sum) + 64'd8192) >> 14);
			end
		end
		return tab;
	endfunction

	localparam cos_tab_t COS_TAB = build_cos_tab();

	typedef enum logic [4:0] {
		LN_IDLE, LN_MODA, LN_MODB, LN_MUL1, LN_MUL2, LN_SQRT, LN_XGO, LN_XWAIT,
		LN_LOG2E, LN_TFRAC, LN_EMUL, LN_EGO, LN_EWAIT, LN_LAM, LN_LNP, LN_LNSQ,
		LN_LNMUL, LN_TERM, LN_DONE
	} lane_state_t;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_SUM, ST_CMP} top_state_t;

	typedef struct packed {
		logic load;
		logic sum_en;
		logic cmp_en;
	} merge_ctrl_t;

endpackage

[hw/rtl/plr_div.sv]
module plr_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [plr_pkg::DIV_W-1:0] dividend,
	input  logic [plr_pkg::DVS_W-1:0] divisor,
	output logic                       done,
	output logic [plr_pkg::DIV_W-1:0] quotient
);
	import plr_pkg::*;

	localparam int CNT_BITS = $clog2(DIV_W);

	logic                busy_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [DVS_W-1:0]    dvs_q;
	logic [DVS_W-1:0]    rem_q;
	logic [DIV_W-1:0]    quo_q;
	logic [DVS_W:0]      trial;
	logic                fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_BITS'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[hw/rtl/plr_lane.sv]
module plr_lane #(
	parameter int LANE_IDX = 0
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [plr_pkg::CNT_W-1:0]          count,
	input  logic [plr_pkg::RAD_W-1:0]          cand_radius,
	input  logic [plr_pkg::DEG_W-1:0]          cand_angle,
	input  logic [plr_pkg::INT_W-1:0]          cand_intensity,
	input  logic [plr_pkg::RAD_W-1:0]          ring_radius,
	input  logic [plr_pkg::RAD_W-1:0]          attenuation_length,
	input  logic [plr_pkg::DEG_W-1:0]          sensor_spacing,
	output logic                               done,
	output logic signed [plr_pkg::LANE_W-1:0]  result
);
	import plr_pkg::*;

	localparam logic [ANG_W-1:0] LANE_MUL = ANG_W'(LANE_IDX);

	lane_state_t state_q, state_d;

	logic [CNT_W-1:0]  cnt_q;
	logic [RAD_W-1:0]  r_q;
	logic [DEG_W-1:0]  th_q;
	logic [INT_W-1:0]  n0_q;
	logic [ANG_W-1:0]  ang_q;
	logic [20:0]       rsum_q;
	logic [19:0]       rprod_q;
	logic signed [18:0] cos_q;
	logic [38:0]       sqv_q, res_q, bit_q;
	logic [27:0]       x_q;
	logic [28:0]       y_q;
	logic [29:0]       t_q;
	logic [12:0]       k_q;
	logic [30:0]       term_q;
	logic signed [31:0] esum_q;
	logic [3:0]        i_q;
	logic [29:0]       p_q;
	logic [27:0]       lam_q;
	logic [4:0]        pos_q;
	logic [31:0]       m_q;
	logic [15:0]       frac_q;
	logic [3:0]        j_q;
	logic signed [22:0] ln_q;
	logic signed [LANE_W-1:0] result_q;

	// divider hookup
	logic             div_start, div_done;
	logic [DIV_W-1:0] div_num, div_quo;
	logic [DVS_W-1:0] div_den;

	plr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	// angle fold into first quadrant
	logic [9:0]  fa;
	logic [6:0]  fk;
	logic        fneg;
	logic signed [18:0] cos_s;
	always_comb begin
		fa = ang_q[9:0];
		priority if (fa <= 10'(QUARTER_TURN)) begin
			fk = fa[6:0];
			fneg = 1'b0;
		end else if (fa <= 10'(HALF_TURN)) begin
			fk = 7'(10'(HALF_TURN) - fa);
			fneg = 1'b1;
		end else if (fa <= 10'(THREE_QUARTER)) begin
			fk = 7'(fa - 10'(HALF_TURN));
			fneg = 1'b1;
		end else begin
			fk = 7'(10'(FULL_TURN) - fa);
			fneg = 1'b0;
		end
		cos_s = fneg ? -$signed({2'b0, COS_TAB[fk]}) : $signed({2'b0, COS_TAB[fk]});
	end

	// combinational datapath pieces
	logic [DEG_W-1:0]   thm;
	logic [10:0]        av;
	logic signed [39:0] rps, cross_p, d2v, base;
	logic [38:0]        srb;
	logic [58:0]        yp;
	logic [45:0]        tp;
	logic [60:0]        pp;
	logic [30:0]        ev;
	logic [13:0]        sh;
	logic [42:0]        lp;
	logic [42:0]        lsh;
	logic [27:0]        lam;
	logic [4:0]         pos;
	logic [57:0]        mext;
	logic [63:0]        sq;
	logic [31:0]        mn;
	logic [50:0]        lp2;
	logic signed [LANE_W-1:0] prodt;
	logic signed [31:0] qext;

	always_comb begin
		thm   = (th_q >= DEG_W'(FULL_TURN)) ? DEG_W'(th_q - DEG_W'(FULL_TURN)) : th_q;
		av    = 11'(ang_q) + 11'(FULL_TURN) - 11'(thm);
		if (av >= 11'(FULL_TURN)) av = av - 11'(FULL_TURN);
		rps   = $signed({20'b0, rprod_q});
		cross_p = rps * cos_q;
		base  = $signed({3'b0, rsum_q, 16'b0});
		d2v   = base - (cross_p <<< 1);
		srb   = res_q + bit_q;
		yp    = x_q * LOG2E_Q30;
		tp    = y_q[15:0] * LN2_Q30;
		pp    = term_q * t_q;
		qext  = $signed({2'b0, div_quo});
		ev    = esum_q[31] ? '0 : esum_q[30:0];
		sh    = 14'(k_q) + 14'd14;
		lp    = n0_q * ev;
		lsh   = lp >> sh[5:0];
		lam   = (sh >= 14'd63) ? '0 : lsh[27:0];
		pos   = '0;
		for (int b = 0; b < 28; b++) begin
			if (lam_q[b]) pos = 5'(b);
		end
		mext  = {lam_q, 30'b0} >> pos;
		sq    = m_q * m_q;
		mn    = sq[61:30];
		lp2   = {pos_q, frac_q} * LN2_Q30;
		prodt = $signed({1'b0, cnt_q}) * ln_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			LN_IDLE, LN_DONE: if (start) state_d = LN_MODA;
			LN_MODA:  if (ang_q < ANG_W'(FULL_TURN)) state_d = LN_MODB;
			LN_MODB:  state_d = LN_MUL1;
			LN_MUL1:  state_d = LN_MUL2;
			LN_MUL2:  state_d = LN_SQRT;
			LN_SQRT:  if (bit_q[0]) state_d = LN_XGO;
			LN_XGO:   state_d = LN_XWAIT;
			LN_XWAIT: if (div_done) state_d = LN_LOG2E;
			LN_LOG2E: state_d = LN_TFRAC;
			LN_TFRAC: state_d = LN_EMUL;
			LN_EMUL:  state_d = LN_EGO;
			LN_EGO:   state_d = LN_EWAIT;
			LN_EWAIT: if (div_done) state_d = (i_q == 4'd12) ? LN_LAM : LN_EMUL;
			LN_LAM:   state_d = LN_LNP;
			LN_LNP:   state_d = LN_LNSQ;
			LN_LNSQ:  if (j_q == 4'd15) state_d = LN_LNMUL;
			LN_LNMUL: state_d = LN_TERM;
			LN_TERM:  state_d = LN_DONE;
			default:  state_d = LN_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		done      = (state_q == LN_DONE);
		div_start = (state_q == LN_XGO) || (state_q == LN_EGO);
		if (state_q == LN_XGO) begin
			div_num = DIV_W'({res_q[19:0], 8'b0});
			div_den = (attenuation_length == '0) ? DVS_W'(1) : attenuation_length;
		end else begin
			div_num = p_q;
			div_den = DVS_W'(i_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= LN_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			LN_IDLE, LN_DONE: begin
				if (start) begin
					cnt_q <= count;
					r_q   <= cand_radius;
					th_q  <= cand_angle;
					n0_q  <= cand_intensity;
					ang_q <= LANE_MUL * ANG_W'(sensor_spacing);
				end
			end
			LN_MODA: if (ang_q >= ANG_W'(FULL_TURN)) ang_q <= ang_q - ANG_W'(FULL_TURN);
			LN_MODB: ang_q <= ANG_W'(av);
			LN_MUL1: begin
				rsum_q  <= 21'(20'(r_q) * 20'(r_q)) + 21'(20'(ring_radius) * 20'(ring_radius));
				rprod_q <= 20'(r_q) * 20'(ring_radius);
				cos_q   <= cos_s;
			end
			LN_MUL2: begin
				sqv_q <= d2v[39] ? '0 : d2v[38:0];
				res_q <= '0;
				bit_q <= {1'b1, 38'b0};
			end
			LN_SQRT: begin
				if (sqv_q >= srb) begin
					sqv_q <= sqv_q - srb;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			LN_XGO: ;
			LN_XWAIT: if (div_done) x_q <= div_quo[27:0];
			LN_LOG2E: y_q <= yp[58:30];
			LN_TFRAC: begin
				t_q    <= tp[45:16];
				k_q    <= y_q[28:16];
				term_q <= 31'h4000_0000;
				esum_q <= 32'sh4000_0000;
				i_q    <= 4'd1;
			end
			LN_EMUL: p_q <= pp[59:30];
			LN_EGO: ;
			LN_EWAIT: begin
				if (div_done) begin
					term_q <= {1'b0, div_quo};
					esum_q <= i_q[0] ? esum_q - qext : esum_q + qext;
					i_q    <= i_q + 4'd1;
				end
			end
			LN_LAM: lam_q <= (lam == '0) ? 28'd1 : lam;
			LN_LNP: begin
				pos_q  <= pos;
				m_q    <= mext[31:0];
				frac_q <= '0;
				j_q    <= '0;
			end
			LN_LNSQ: begin
				frac_q <= {frac_q[14:0], mn[31]};
				m_q    <= mn[31] ? (mn >> 1) : mn;
				j_q    <= j_q + 4'd1;
			end
			LN_LNMUL: ln_q <= $signed({2'b0, lp2[50:30]}) - LN_2P16_Q16;
			LN_TERM:  result_q <= prodt - $signed({10'b0, lam_q});
			default: ;
		endcase
	end

	assign result = result_q;

endmodule

[hw/rtl/plr_merge.sv]
module plr_merge #(
	parameter int NUM_SENSORS = plr_pkg::NUM_SENSORS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  plr_pkg::merge_ctrl_t              ctrl,
	input  logic signed [plr_pkg::LANE_W-1:0] terms [NUM_SENSORS],
	input  logic [plr_pkg::RAD_W-1:0]         cand_radius,
	input  logic [plr_pkg::DEG_W-1:0]         cand_angle,
	input  logic [plr_pkg::INT_W-1:0]         cand_intensity,
	input  logic                              first_candidate,
	output logic signed [plr_pkg::LL_W-1:0]   log_likelihood,
	output logic signed [plr_pkg::LL_W-1:0]   best_value,
	output logic [plr_pkg::RAD_W-1:0]         best_radius_out,
	output logic [plr_pkg::DEG_W-1:0]         best_angle_out,
	output logic [plr_pkg::INT_W-1:0]         best_intensity_out,
	output logic                              is_new_best
);
	import plr_pkg::*;

	logic [RAD_W-1:0] r_q;
	logic [DEG_W-1:0] th_q;
	logic [INT_W-1:0] n0_q;
	logic             first_q;
	logic signed [LL_W-1:0] sum_s1;

	logic signed [LL_W-1:0] best_score_q;
	logic [RAD_W-1:0] best_radius_q;
	logic [DEG_W-1:0] best_angle_q;
	logic [INT_W-1:0] best_intensity_q;

	logic signed [LL_W-1:0] sum_d, base_score, nxt_score;
	logic [RAD_W-1:0] nxt_radius;
	logic [DEG_W-1:0] nxt_angle;
	logic [INT_W-1:0] nxt_intensity;
	logic             nxt_new;

	always_comb begin
		sum_d = '0;
		for (int m = 0; m < NUM_SENSORS; m++) begin
			sum_d = sum_d + LL_W'(terms[m]);
		end
	end

	// first candidate zeroes the stored best before the compare
	always_comb begin
		base_score    = first_q ? '0 : best_score_q;
		nxt_score     = base_score;
		nxt_radius    = first_q ? '0 : best_radius_q;
		nxt_angle     = first_q ? '0 : best_angle_q;
		nxt_intensity = first_q ? '0 : best_intensity_q;
		nxt_new       = 1'b0;
		if (sum_s1 > base_score) begin
			nxt_score     = sum_s1;
			nxt_radius    = r_q;
			nxt_angle     = th_q;
			nxt_intensity = n0_q;
			nxt_new       = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_score_q     <= '0;
			best_radius_q    <= '0;
			best_angle_q     <= '0;
			best_intensity_q <= '0;
		end else if (ctrl.cmp_en) begin
			best_score_q     <= nxt_score;
			best_radius_q    <= nxt_radius;
			best_angle_q     <= nxt_angle;
			best_intensity_q <= nxt_intensity;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			r_q     <= cand_radius;
			th_q    <= cand_angle;
			n0_q    <= cand_intensity;
			first_q <= first_candidate;
		end
		if (ctrl.sum_en) sum_s1 <= sum_d;
		if (ctrl.cmp_en) begin
			log_likelihood     <= sum_s1;
			best_value         <= nxt_score;
			best_radius_out    <= nxt_radius;
			best_angle_out     <= nxt_angle;
			best_intensity_out <= nxt_intensity;
			is_new_best        <= nxt_new;
		end
	end

endmodule

[hw/rtl/poisson_likelihood_ring_search.sv]
// Poisson log-likelihood of one candidate source against a ring of sensors,
// with a running best-candidate tracker.
//
// Input channel (in_valid / in_stall): one transfer carries the sensor counts
// and one candidate (radius, angle, intensity, first flag). Output channel
// (out_valid / out_stall): one result transfer per input transfer, in order.
// Config: APB-style, ring_radius at 0x0, attenuation_length at 0x4,
// sensor_spacing at 0x8; write only while the block is idle.
//
// Each lane first brings its angle (lane index * sensor_spacing) below 360
// degrees by repeated subtraction of 360, then runs a 20-step square root, a
// bit-serial divide for the distance ratio, twelve exp terms on the same
// divider, then 16 log squarings. Lanes start together and hold done until
// the next start; a sum stage and a compare stage follow. One item is in
// flight: the next transfer can be taken in the same cycle that out_valid
// rises, once the compare stage has handed its result on.
// in_stall is high while an item is worked on. A finished result sits in the
// output register, so the next item can enter while out_stall holds it; the
// compare stage waits for that register to empty. Reset clears the best
// candidate to zero and loads the register defaults (150, 23, 45).
module poisson_likelihood_ring_search #(
	parameter int NUM_SENSORS = plr_pkg::NUM_SENSORS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// config
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [plr_pkg::PADDR_W-1:0]     paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [plr_pkg::CNT_W-1:0]       count_0,
	input  logic [plr_pkg::CNT_W-1:0]       count_1,
	input  logic [plr_pkg::CNT_W-1:0]       count_2,
	input  logic [plr_pkg::CNT_W-1:0]       count_3,
	input  logic [plr_pkg::CNT_W-1:0]       count_4,
	input  logic [plr_pkg::CNT_W-1:0]       count_5,
	input  logic [plr_pkg::CNT_W-1:0]       count_6,
	input  logic [plr_pkg::CNT_W-1:0]       count_7,
	input  logic [plr_pkg::RAD_W-1:0]       cand_radius,
	input  logic [plr_pkg::DEG_W-1:0]       cand_angle,
	input  logic [plr_pkg::INT_W-1:0]       cand_intensity,
	input  logic                            first_candidate,
	// output channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [plr_pkg::LL_W-1:0] log_likelihood,
	output logic signed [plr_pkg::LL_W-1:0] best_value,
	output logic [plr_pkg::RAD_W-1:0]       best_radius_out,
	output logic [plr_pkg::DEG_W-1:0]       best_angle_out,
	output logic [plr_pkg::INT_W-1:0]       best_intensity_out,
	output logic                            is_new_best
);
	import plr_pkg::*;

	// ---------------- config registers ----------------
	logic [RAD_W-1:0] ring_radius_q;
	logic [RAD_W-1:0] atten_len_q;
	logic [DEG_W-1:0] spacing_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_radius_q <= RAD_W'(150);
			atten_len_q   <= RAD_W'(23);
			spacing_q     <= DEG_W'(45);
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_RING_RADIUS: ring_radius_q <= pwdata[RAD_W-1:0];
				REG_ATTEN_LEN:   atten_len_q   <= pwdata[RAD_W-1:0];
				REG_SPACING:     spacing_q     <= pwdata[DEG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_RING_RADIUS: prdata = 32'(ring_radius_q);
			REG_ATTEN_LEN:   prdata = 32'(atten_len_q);
			REG_SPACING:     prdata = 32'(spacing_q);
			default:         prdata = '0;
		endcase
	end

	// ---------------- control ----------------
	top_state_t  state_q, state_d;
	merge_ctrl_t mctrl;
	logic        accept;
	logic        out_valid_q;
	logic [NUM_SENSORS-1:0] lane_done;

	assign accept = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_RUN;
			ST_RUN:  if (&lane_done) state_d = ST_SUM;
			ST_SUM:  state_d = ST_CMP;
			ST_CMP:  if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall     = (state_q != ST_IDLE);
		mctrl.load   = accept;
		mctrl.sum_en = (state_q == ST_SUM);
		mctrl.cmp_en = (state_q == ST_CMP) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mctrl.cmp_en) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// ---------------- lanes ----------------
	logic [CNT_W-1:0] counts [MAX_SENSORS];
	logic signed [LANE_W-1:0] terms [NUM_SENSORS];

	assign counts[0] = count_0;
	assign counts[1] = count_1;
	assign counts[2] = count_2;
	assign counts[3] = count_3;
	assign counts[4] = count_4;
	assign counts[5] = count_5;
	assign counts[6] = count_6;
	assign counts[7] = count_7;

	for (genvar m = 0; m < NUM_SENSORS; m++) begin : g_lane
		plr_lane #(.LANE_IDX(m)) u_lane (
			.clk                (clk),
			.arst_n             (arst_n),
			.start              (accept),
			.count              (counts[m]),
			.cand_radius        (cand_radius),
			.cand_angle         (cand_angle),
			.cand_intensity     (cand_intensity),
			.ring_radius        (ring_radius_q),
			.attenuation_length (atten_len_q),
			.sensor_spacing     (spacing_q),
			.done               (lane_done[m]),
			.result             (terms[m])
		);
	end

	// ---------------- sum, compare, best tracking ----------------
	plr_merge #(.NUM_SENSORS(NUM_SENSORS)) u_merge (
		.clk                (clk),
		.arst_n             (arst_n),
		.ctrl               (mctrl),
		.terms              (terms),
		.cand_radius        (cand_radius),
		.cand_angle         (cand_angle),
		.cand_intensity     (cand_intensity),
		.first_candidate    (first_candidate),
		.log_likelihood     (log_likelihood),
		.best_value         (best_value),
		.best_radius_out    (best_radius_out),
		.best_angle_out     (best_angle_out),
		.best_intensity_out (best_intensity_out),
		.is_new_best        (is_new_best)
	);

	// ---------------- assertions ----------------
	// lanes hold done until the next start, so all are done when the sum is taken
	a_lanes_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SUM |-> &lane_done)
		else $error("sum taken before all lanes finished");

	a_cmp_shows: assert property (@(posedge clk) disable iff (!arst_n)
		mctrl.cmp_en |=> out_valid)
		else $error("compare result not presented");

	a_new_best: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_new_best |-> best_value == log_likelihood)
		else $error("new best does not match this likelihood");

	// best restarts at zero on a first candidate and otherwise only rises
	a_best_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !best_value[LL_W-1])
		else $error("best value went negative");

endmodule
